### src/pfct_pkg.sv
// ----------------------------------------------------------------------------
// pfct_pkg
// Shared types and constants of the per-port flow and connection tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfct_pkg;

  localparam int PORT_SLOTS_DEF   = 64;
  localparam int CONN_ENTRIES_DEF = 1024;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EVENT   = 2'd1,
    REQ_PUBLISH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_SCAN,
    S_CONN_SCAN,
    S_CNT_READ,
    S_CNT_UPD
  } state_t;

  typedef struct packed {
    logic [63:0] in_now;
    logic [63:0] in_prev;
    logic [63:0] out_now;
    logic [63:0] out_prev;
    logic [10:0] active;
  } cnt_word_t;

  typedef struct packed {
    logic        valid;
    logic        udp;
    logic [15:0] port;
    logic [31:0] src;
    logic [31:0] dst;
  } conn_word_t;

endpackage

`default_nettype wire

### src/port_flow_connection_tracker_unit.sv
// ----------------------------------------------------------------------------
// port_flow_connection_tracker_unit
// Per-port TCP/UDP byte counters with a connection table and active counts.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beats
//  ---------+----------------------+---------------------------------------
//  request  | start, busy          | req_type, slot, dest_port, proto_num,
//           |                      | src_addr, dst_addr, sent/recv_bytes,
//           |                      | closing
//  result   | done (one cycle)     | status, in_delta, out_delta,
//           |                      | active_conns
//
//  load, unknown and items ignored at decode: result in the cycle after accept.
//  publish: passes through the counter memory read and write back states.
//  event: the slot memory and, if a valid slot holds the port, then the
//  connection memory are scanned one entry per cycle.
//  after reset a clearing pass over all CONN_ENTRIES entries runs with busy high.
//  the receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module port_flow_connection_tracker_unit #(
  parameter int PORT_SLOTS   = pfct_pkg::PORT_SLOTS_DEF,
  parameter int CONN_ENTRIES = pfct_pkg::CONN_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [5:0]  slot,
  input  wire logic [15:0] dest_port,
  input  wire logic [7:0]  proto_num,
  input  wire logic [31:0] src_addr,
  input  wire logic [31:0] dst_addr,
  input  wire logic [31:0] sent_bytes,
  input  wire logic [31:0] recv_bytes,
  input  wire logic        closing,
  output logic             done,
  output logic [1:0]       status,
  output logic [63:0]      in_delta,
  output logic [63:0]      out_delta,
  output logic [10:0]      active_conns
);

  localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int CW = $clog2(CONN_ENTRIES);
  localparam int CNT_DEPTH = 2 * PORT_SLOTS;
  localparam logic [SW-1:0] SLOT_LAST = SW'(PORT_SLOTS - 1);
  localparam logic [CW-1:0] CONN_LAST = CW'(CONN_ENTRIES - 1);

  // memories
  logic [15:0]               slot_mem [PORT_SLOTS];
  pfct_pkg::conn_word_t      conn_mem [CONN_ENTRIES];
  pfct_pkg::cnt_word_t       cnt_mem  [CNT_DEPTH];
  logic [15:0]               slot_rd;
  pfct_pkg::conn_word_t      conn_rd;
  pfct_pkg::cnt_word_t       cnt_rd;

  // control state
  pfct_pkg::state_t          state, state_next;
  logic [PORT_SLOTS-1:0]     slot_ok;
  logic [CNT_DEPTH-1:0]      cnt_vld;
  logic [SW-1:0]             slot_scan, slot_chk, sel_slot;
  logic [CW-1:0]             conn_scan, conn_chk, found_idx, free_idx;
  logic                      chk_vld, found, free_ok;

  // captured item
  pfct_pkg::req_t            req_q;
  logic [15:0]               port_q;
  logic                      udp_q;
  logic [31:0]               src_q, dst_q, sent_q, recv_q;
  logic                      closing_q;

  // decode and control
  logic                      accept, slot_in_range, proto_ok, load_go, ev_go, pub_go;
  logic                      slot_match, conn_hit;
  logic [SW:0]               cnt_idx;
  logic                      slot_we, cnt_we, conn_we;
  logic [CW-1:0]             conn_wa;
  pfct_pkg::conn_word_t      conn_wd;
  pfct_pkg::cnt_word_t       cnt_cur, cnt_wd;
  logic                      fin;
  pfct_pkg::status_t         fin_status;
  logic [63:0]               fin_in, fin_out;
  logic [10:0]               fin_act;

  assign busy    = (state != pfct_pkg::S_IDLE);
  assign accept  = start && (state == pfct_pkg::S_IDLE);
  assign cnt_idx = {sel_slot, udp_q};

  always_comb begin
    slot_in_range = ({26'd0, slot} < 32'(PORT_SLOTS));
    proto_ok      = (proto_num == pfct_pkg::PROTO_TCP) || (proto_num == pfct_pkg::PROTO_UDP);
    load_go       = (req_type == pfct_pkg::REQ_LOAD) && slot_in_range;
    ev_go         = (req_type == pfct_pkg::REQ_EVENT) && (dest_port != 16'd0) && proto_ok;
    pub_go        = (req_type == pfct_pkg::REQ_PUBLISH) && slot_in_range && proto_ok &&
                    slot_ok[SW'(slot)];
    slot_match    = chk_vld && slot_ok[slot_chk] && (slot_rd == port_q);
    conn_hit      = conn_rd.valid && (conn_rd.udp == udp_q) && (conn_rd.port == port_q) &&
                    (conn_rd.src == src_q) && (conn_rd.dst == dst_q);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfct_pkg::S_CLEAR: begin
        if (conn_scan == CONN_LAST) state_next = pfct_pkg::S_IDLE;
      end
      pfct_pkg::S_IDLE: begin
        if (accept && ev_go) state_next = pfct_pkg::S_SLOT_SCAN;
        else if (accept && pub_go) state_next = pfct_pkg::S_CNT_READ;
      end
      pfct_pkg::S_SLOT_SCAN: begin
        if (slot_match) state_next = pfct_pkg::S_CONN_SCAN;
        else if (chk_vld && slot_chk == SLOT_LAST) state_next = pfct_pkg::S_IDLE;
      end
      pfct_pkg::S_CONN_SCAN: begin
        if (chk_vld && conn_chk == CONN_LAST) state_next = pfct_pkg::S_CNT_READ;
      end
      pfct_pkg::S_CNT_READ: state_next = pfct_pkg::S_CNT_UPD;
      pfct_pkg::S_CNT_UPD:  state_next = pfct_pkg::S_IDLE;
      default:              state_next = pfct_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine: memory writes and the finishing result
  always_comb begin
    slot_we    = 1'b0;
    cnt_we     = 1'b0;
    conn_we    = 1'b0;
    conn_wa    = found ? found_idx : free_idx;
    conn_wd    = '0;
    cnt_cur    = cnt_vld[cnt_idx] ? cnt_rd : '0;
    cnt_wd     = cnt_cur;
    fin        = 1'b0;
    fin_status = pfct_pkg::STAT_IGNORED;
    fin_in     = '0;
    fin_out    = '0;
    fin_act    = '0;
    unique case (state)
      pfct_pkg::S_CLEAR: begin
        conn_we = 1'b1;
        conn_wa = conn_scan;
      end
      pfct_pkg::S_IDLE: begin
        if (accept && !ev_go && !pub_go) begin
          fin = 1'b1;
          if (load_go) begin
            slot_we    = 1'b1;
            fin_status = pfct_pkg::STAT_DONE;
          end
        end
      end
      pfct_pkg::S_SLOT_SCAN: begin
        // no valid slot holds the port
        fin = !slot_match && chk_vld && (slot_chk == SLOT_LAST);
      end
      pfct_pkg::S_CONN_SCAN, pfct_pkg::S_CNT_READ: begin
      end
      pfct_pkg::S_CNT_UPD: begin
        cnt_we     = 1'b1;
        fin        = 1'b1;
        fin_status = pfct_pkg::STAT_DONE;
        if (req_q == pfct_pkg::REQ_EVENT) begin
          cnt_wd.in_now  = cnt_cur.in_now + 64'(recv_q);
          cnt_wd.out_now = cnt_cur.out_now + 64'(sent_q);
          if (found && closing_q) begin
            conn_we = 1'b1;
            if (cnt_cur.active != 11'd0) cnt_wd.active = cnt_cur.active - 11'd1;
          end else if (!found && free_ok && !closing_q) begin
            conn_we = 1'b1;
            conn_wd = '{valid: 1'b1, udp: udp_q, port: port_q, src: src_q, dst: dst_q};
            if (cnt_cur.active != pfct_pkg::COUNT_MAX) cnt_wd.active = cnt_cur.active + 11'd1;
          end
          if (!found && !free_ok) fin_status = pfct_pkg::STAT_FULL;
        end else if (cnt_cur.in_now != cnt_cur.in_prev) begin
          fin_in          = cnt_cur.in_now - cnt_cur.in_prev;
          fin_out         = cnt_cur.out_now - cnt_cur.out_prev;
          cnt_wd.in_prev  = cnt_cur.in_now;
          cnt_wd.out_prev = cnt_cur.out_now;
        end
        fin_act = cnt_wd.active;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[SW'(slot)] <= dest_port;
    slot_rd <= slot_mem[slot_scan];
  end

  always_ff @(posedge clk) begin
    if (conn_we) conn_mem[conn_wa] <= conn_wd;
    conn_rd <= conn_mem[conn_scan];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_idx] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfct_pkg::S_CLEAR;
      conn_scan <= '0;
      slot_scan <= '0;
      chk_vld   <= 1'b0;
      found     <= 1'b0;
      free_ok   <= 1'b0;
      slot_ok   <= '0;
      cnt_vld   <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      unique case (state)
        pfct_pkg::S_CLEAR: begin
          conn_scan <= conn_scan + 1'b1;
        end
        pfct_pkg::S_IDLE: begin
          slot_scan <= '0;
          conn_scan <= '0;
          chk_vld   <= 1'b0;
          found     <= 1'b0;
          free_ok   <= 1'b0;
          if (slot_we) begin
            slot_ok[SW'(slot)]       <= (dest_port != 16'd0);
            cnt_vld[{SW'(slot), 1'b0}] <= 1'b0;
            cnt_vld[{SW'(slot), 1'b1}] <= 1'b0;
          end
        end
        pfct_pkg::S_SLOT_SCAN: begin
          chk_vld <= !slot_match;
          if (slot_scan != SLOT_LAST) slot_scan <= slot_scan + 1'b1;
        end
        pfct_pkg::S_CONN_SCAN: begin
          chk_vld <= 1'b1;
          if (conn_scan != CONN_LAST) conn_scan <= conn_scan + 1'b1;
          if (chk_vld) begin
            if (conn_hit && !found) begin
              found <= 1'b1;
            end else if (!conn_rd.valid && !free_ok) begin
              free_ok <= 1'b1;
            end
          end
        end
        pfct_pkg::S_CNT_READ: begin
        end
        pfct_pkg::S_CNT_UPD: begin
          cnt_vld[cnt_idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= pfct_pkg::req_t'(req_type);
      port_q    <= dest_port;
      udp_q     <= (proto_num == pfct_pkg::PROTO_UDP);
      src_q     <= src_addr;
      dst_q     <= dst_addr;
      sent_q    <= sent_bytes;
      recv_q    <= recv_bytes;
      closing_q <= closing;
      sel_slot  <= SW'(slot);
    end
    if (state == pfct_pkg::S_SLOT_SCAN) begin
      slot_chk <= slot_scan;
      if (slot_match) sel_slot <= slot_chk;
    end
    if (state == pfct_pkg::S_CONN_SCAN) begin
      conn_chk <= conn_scan;
      if (chk_vld && conn_hit && !found) found_idx <= conn_chk;
      if (chk_vld && !conn_rd.valid && !free_ok) free_idx <= conn_chk;
    end
    if (fin) begin
      status       <= fin_status;
      in_delta     <= fin_in;
      out_delta    <= fin_out;
      active_conns <= fin_act;
    end
  end

endmodule

`default_nettype wire

### src/pfct_checker.sv
// ----------------------------------------------------------------------------
// pfct_checker
// Port-level checks of the flow tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfct_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [63:0] in_delta,
  input wire logic [63:0] out_delta,
  input wire logic [10:0] active_conns
);

  // reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("no clearing pass after reset");

  // an accepted beat either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted beat lost");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == pfct_pkg::STAT_DONE || status == pfct_pkg::STAT_IGNORED ||
              status == pfct_pkg::STAT_FULL))
    else $error("bad status code");

  a_delta_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != pfct_pkg::STAT_DONE) |-> (in_delta == 64'd0 && out_delta == 64'd0))
    else $error("deltas on a failed beat");

  a_ignored_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == pfct_pkg::STAT_IGNORED) |-> (active_conns == 11'd0))
    else $error("count on an ignored beat");

endmodule

bind port_flow_connection_tracker_unit pfct_checker u_pfct_checker (.*);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the port flow tracker: a driver issues load, event,
// publish and unknown-type beats from a queue, a scoreboard predicts every
// result and the monitor compares each done beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = pfct_pkg::PORT_SLOTS_DEF;
  localparam int NCONN = pfct_pkg::CONN_ENTRIES_DEF;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] REQ_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  slot;
    logic [15:0] dest_port;
    logic [7:0]  proto_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] sent_bytes;
    logic [31:0] recv_bytes;
    logic        closing;
  } flow_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] in_delta;
    logic [63:0] out_delta;
    logic [10:0] active_conns;
  } flow_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0]  req_type = '0;
  logic [5:0]  slot = '0;
  logic [15:0] dest_port = '0;
  logic [7:0]  proto_num = '0;
  logic [31:0] src_addr = '0, dst_addr = '0, sent_bytes = '0, recv_bytes = '0;
  logic        closing = 1'b0;
  logic [1:0]  status;
  logic [63:0] in_delta, out_delta;
  logic [10:0] active_conns;

  port_flow_connection_tracker_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .slot(slot), .dest_port(dest_port),
    .proto_num(proto_num), .src_addr(src_addr), .dst_addr(dst_addr),
    .sent_bytes(sent_bytes), .recv_bytes(recv_bytes), .closing(closing),
    .done(done), .status(status), .in_delta(in_delta), .out_delta(out_delta),
    .active_conns(active_conns)
  );

  initial forever #2 clk = ~clk;

  // predictor state
  logic [16:0] slot_tab [NSLOT];
  logic [63:0] rx_now [2*NSLOT], rx_mark [2*NSLOT];
  logic [63:0] tx_now [2*NSLOT], tx_mark [2*NSLOT];
  logic [10:0] conn_cnt [2*NSLOT];
  logic [63:0] conn_key [NCONN];
  logic [17:0] conn_tag [NCONN];

  flow_req_t pending_q [$];
  flow_rsp_t expected_q [$];
  int errors = 0;
  int idle_left = 0;
  bit calm = 1'b0;
  bit hold_drain = 1'b0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  function automatic flow_rsp_t predict_flow(flow_req_t r);
    flow_rsp_t o;
    int s, pb, idx, hit, free_i;
    logic [17:0] tag;
    logic [63:0] key;
    o = '0;
    pb = (r.proto_num == pfct_pkg::PROTO_TCP) ? 0 :
         (r.proto_num == pfct_pkg::PROTO_UDP) ? 1 : -1;
    case (r.req_type)
      pfct_pkg::REQ_LOAD: begin
        slot_tab[r.slot] = (r.dest_port != 0) ? {1'b1, r.dest_port} : '0;
        for (int k = 0; k < 2; k++) begin
          idx = r.slot*2 + k;
          rx_now[idx] = 0; rx_mark[idx] = 0; tx_now[idx] = 0; tx_mark[idx] = 0;
          conn_cnt[idx] = 0;
        end
        o.status = pfct_pkg::STAT_DONE;
      end
      pfct_pkg::REQ_EVENT: begin
        s = -1;
        if (r.dest_port != 0 && pb >= 0)
          for (int k = NSLOT-1; k >= 0; k--)
            if (slot_tab[k] == {1'b1, r.dest_port}) s = k;
        if (s < 0) begin
          o.status = pfct_pkg::STAT_IGNORED;
        end else begin
          idx = s*2 + pb;
          rx_now[idx] += r.recv_bytes;
          tx_now[idx] += r.sent_bytes;
          tag = {1'b1, pb[0], r.dest_port};
          key = {r.src_addr, r.dst_addr};
          hit = -1; free_i = -1;
          for (int i = 0; i < NCONN; i++) begin
            if (hit < 0) begin
              if (conn_tag[i][17]) begin
                if (conn_tag[i] == tag && conn_key[i] == key) hit = i;
              end else if (free_i < 0) begin
                free_i = i;
              end
            end
          end
          o.status = pfct_pkg::STAT_DONE;
          if (hit < 0) begin
            if (free_i < 0) begin
              o.status = pfct_pkg::STAT_FULL;
            end else if (!r.closing) begin
              conn_tag[free_i] = tag;
              conn_key[free_i] = key;
              if (conn_cnt[idx] < pfct_pkg::COUNT_MAX) conn_cnt[idx]++;
            end
          end else if (r.closing) begin
            conn_tag[hit] = '0;
            if (conn_cnt[idx] > 0) conn_cnt[idx]--;
          end
          o.active_conns = conn_cnt[idx];
        end
      end
      pfct_pkg::REQ_PUBLISH: begin
        if (pb < 0 || !slot_tab[r.slot][16]) begin
          o.status = pfct_pkg::STAT_IGNORED;
        end else begin
          idx = r.slot*2 + pb;
          if (rx_now[idx] != rx_mark[idx]) begin
            o.in_delta = rx_now[idx] - rx_mark[idx];
            o.out_delta = tx_now[idx] - tx_mark[idx];
            rx_mark[idx] = rx_now[idx];
            tx_mark[idx] = tx_now[idx];
          end
          o.status = pfct_pkg::STAT_DONE;
          o.active_conns = conn_cnt[idx];
        end
      end
      default: o.status = pfct_pkg::STAT_IGNORED;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_q.push_back(predict_flow(pending_q.pop_front()));
        idle_left = calm ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      end else if (idle_left > 0 && !(start && busy)) begin
        idle_left--;
      end
      if (start && busy) begin
        // keep holding the beat
      end else if (idle_left > 0 || pending_q.size() == 0 ||
                   (hold_drain && expected_q.size() != 0)) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        req_type <= pending_q[0].req_type;
        slot <= pending_q[0].slot;
        dest_port <= pending_q[0].dest_port;
        proto_num <= pending_q[0].proto_num;
        src_addr <= pending_q[0].src_addr;
        dst_addr <= pending_q[0].dst_addr;
        sent_bytes <= pending_q[0].sent_bytes;
        recv_bytes <= pending_q[0].recv_bytes;
        closing <= pending_q[0].closing;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    flow_rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", status, 0);
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (in_delta !== want.in_delta) report_mismatch("in_delta", in_delta, want.in_delta);
          if (out_delta !== want.out_delta)
            report_mismatch("out_delta", out_delta, want.out_delta);
          if (active_conns !== want.active_conns)
            report_mismatch("active_conns", active_conns, want.active_conns);
        end
      end
      quiet_cycles = (done || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  int ports [8];

  function automatic flow_req_t mk(logic [1:0] rt, logic [5:0] sl, logic [15:0] pt,
                                   logic [7:0] pr, logic [31:0] sa, logic [31:0] da,
                                   logic [31:0] sb, logic [31:0] rb, logic cl);
    flow_req_t r;
    r.req_type = rt; r.slot = sl; r.dest_port = pt; r.proto_num = pr;
    r.src_addr = sa; r.dst_addr = da; r.sent_bytes = sb; r.recv_bytes = rb;
    r.closing = cl;
    return r;
  endfunction

  function automatic logic [7:0] pick_proto();
    int v;
    v = $urandom_range(0, 9);
    return (v < 5) ? pfct_pkg::PROTO_TCP : (v < 9) ? pfct_pkg::PROTO_UDP : 8'($urandom);
  endfunction

  initial begin
    int v;
    flow_req_t r;
    for (int i = 0; i < NSLOT; i++) slot_tab[i] = '0;
    for (int i = 0; i < 2*NSLOT; i++) begin
      rx_now[i] = 0; rx_mark[i] = 0; tx_now[i] = 0; tx_mark[i] = 0; conn_cnt[i] = 0;
    end
    for (int i = 0; i < NCONN; i++) begin
      conn_tag[i] = '0; conn_key[i] = '0;
    end
    ports = '{80, 443, 53, 65535, 1, 8080, 22, 32768};

    // directed beats
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, pfct_pkg::PROTO_TCP, 1, 2, 10, 10, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 0, 80, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 63, 65535, 0, 0, 0, 0, 0, 0));
    // duplicate port
    pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 5, 80, 0, 0, 0, 0, 0, 0));
    // port zero
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 0, pfct_pkg::PROTO_TCP, 1, 2, 3, 4, 0));
    // unknown proto
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, 8'hFF, 1, 2, 3, 4, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, pfct_pkg::PROTO_TCP, '1, '1, '1, '1, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, pfct_pkg::PROTO_TCP, '1, '1, '1, '1, 0));
    // new and closing at once
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 65535, pfct_pkg::PROTO_UDP, 0, 0, 7, 0, 1));
    // recv unchanged
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 63, 0, pfct_pkg::PROTO_UDP, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 0, 0, pfct_pkg::PROTO_TCP, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 0, 0, pfct_pkg::PROTO_TCP, 0, 0, 0, 0, 0));
    // close
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, pfct_pkg::PROTO_TCP, '1, '1, 1, 1, 1));
    // close unknown
    pending_q.push_back(mk(pfct_pkg::REQ_EVENT, 0, 80, pfct_pkg::PROTO_TCP, 9, 9, 1, 1, 1));
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 0, 0, pfct_pkg::PROTO_TCP, 0, 0, 0, 0, 0));
    // invalid slot
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 7, 0, pfct_pkg::PROTO_TCP, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(pfct_pkg::REQ_PUBLISH, 0, 0, 8'd7, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_BAD, 0, 0, 0, 0, 0, 0, 0, 0));
    // disable slot
    pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 5, 0, 0, 0, 0, 0, 0, 0));
    // clears counters
    pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 0, 80, 0, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);

    // pause until drained
    hold_drain = 1'b1;
    @(posedge clk);
    wait (expected_q.size() == 0);
    hold_drain = 1'b0;

    for (int i = 0; i < 8; i++)
      pending_q.push_back(mk(pfct_pkg::REQ_LOAD, 6'(i), 16'(ports[i]), 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < 400; n++) begin
      if (n == 330) begin
        wait (pending_q.size() == 0);
        calm = 1'b1;
      end
      v = $urandom_range(0, 19);
      if (v < 13) begin
        // connections drawn from a small address pool so closes hit
        r = mk(pfct_pkg::REQ_EVENT, 0, 16'(ports[$urandom_range(0, 7)]), pick_proto(),
               ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5),
               ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3),
               $urandom, ($urandom_range(0, 3) == 0) ? 0 : $urandom,
               $urandom_range(0, 2) == 0);
        if ($urandom_range(0, 15) == 0) r.dest_port = 16'($urandom);
      end else if (v < 18) begin
        r = mk(pfct_pkg::REQ_PUBLISH, 6'($urandom_range(0, 9)), 0, pick_proto(),
               0, 0, 0, 0, 0);
        if ($urandom_range(0, 9) == 0) r.slot = 6'($urandom);
      end else if (v < 19) begin
        r = mk(pfct_pkg::REQ_LOAD, 6'($urandom_range(0, 9)),
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(ports[$urandom_range(0, 7)]),
               0, 0, 0, 0, 0, 0);
        if ($urandom_range(0, 9) == 0) r.slot = 6'($urandom);
      end else begin
        r = mk(REQ_BAD, 6'($urandom), 16'($urandom), 8'($urandom), $urandom, $urandom,
               $urandom, $urandom, 1'($urandom));
      end
      pending_q.push_back(r);
    end

    wait (pending_q.size() == 0);
    wait (expected_q.size() == 0);
    repeat (NSLOT + NCONN + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
